// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

   localparam int          ADDR_BITS     = 32;
   localparam int          LEN_BITS      = 6;
   localparam int          TTL_BITS      = 8;
   localparam int          OUT_PORT_BITS = 4;
   localparam int          PORT_MAX_BITS = 8;
   localparam logic [31:0] FULL_MASK     = 32'hffff_ffff;
   localparam logic [5:0]  LEN_MAX       = 6'd32;
   localparam logic        KIND_ADD      = 1'b0;
   localparam logic        KIND_ROUTE    = 1'b1;

   typedef enum logic [1:0] {
      OP_ROUTE,
      OP_UPDATE,
      OP_CLAIM
   } lpr_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_PARK
   } lpr_state_type;

   // addr: masked prefix (add) or destination (route)
   // len/direct/gway: new route (add) or best match so far (route)
   // hit: key matched or slot taken (add), some route matched (route)
   typedef struct packed {
      lpr_op_type            op;
      logic [ADDR_BITS-1:0]  addr;
      logic [LEN_BITS-1:0]   len;
      logic                  hit;
      logic                  direct;
      logic [ADDR_BITS-1:0]  gway;
      logic [TTL_BITS-1:0]   ttl;
   } lpr_word_type;

   typedef struct packed {
      logic                     fwd;
      logic [OUT_PORT_BITS-1:0] port;
      logic [ADDR_BITS-1:0]     nh;
      logic [TTL_BITS-1:0]      ttl;
   } lpr_res_type;

   function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
      return ~(FULL_MASK >> len);
   endfunction

endpackage

// ===== rtl/lpr_cell.sv =====
module lpr_cell import lpr_pkg::*; #(
   parameter int PORT_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_act,
   input  lpr_word_type         in_word,
   input  logic [PORT_BITS-1:0] in_port,
   output logic                 out_act,
   output lpr_word_type         out_word,
   output logic [PORT_BITS-1:0] out_port
);

   logic                 valid_ff, valid_in;
   logic [ADDR_BITS-1:0] prefix_ff, prefix_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 direct_ff, direct_in;
   logic [ADDR_BITS-1:0] gway_ff, gway_in;
   logic [PORT_BITS-1:0] port_ff, port_in;

   logic                 act_ff;
   lpr_word_type         word_ff, word_in;
   logic [PORT_BITS-1:0] lane_ff, lane_in;

   logic                 wr;

   always_comb begin
      word_in   = in_word;
      lane_in   = in_port;
      wr        = 1'b0;
      valid_in  = valid_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      direct_in = direct_ff;
      gway_in   = gway_ff;
      port_in   = port_ff;
      if (in_act) begin
         unique case (in_word.op)
            OP_ROUTE: begin
               if (valid_ff && (((prefix_ff ^ in_word.addr) & len_mask(len_ff)) == '0) &&
                   (!in_word.hit || (len_ff > in_word.len))) begin
                  word_in.hit    = 1'b1;
                  word_in.len    = len_ff;
                  word_in.direct = direct_ff;
                  word_in.gway   = gway_ff;
                  lane_in        = port_ff;
               end
            end
            OP_UPDATE: begin
               if (valid_ff && (prefix_ff == in_word.addr) && (len_ff == in_word.len)) begin
                  wr          = 1'b1;
                  word_in.hit = 1'b1;
               end
            end
            OP_CLAIM: begin
               if (!valid_ff && !in_word.hit) begin
                  wr          = 1'b1;
                  word_in.hit = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (wr) begin
         valid_in  = 1'b1;
         prefix_in = in_word.addr;
         len_in    = in_word.len;
         direct_in = in_word.direct;
         gway_in   = in_word.gway;
         port_in   = in_port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         act_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         act_ff   <= in_act;
      end
      prefix_ff <= prefix_in;
      len_ff    <= len_in;
      direct_ff <= direct_in;
      gway_ff   <= gway_in;
      port_ff   <= port_in;
      word_ff   <= word_in;
      lane_ff   <= lane_in;
   end

   assign out_act  = act_ff;
   assign out_word = word_ff;
   assign out_port = lane_ff;

endmodule

// ===== rtl/ipv4_longest_prefix_router.sv =====
// IPv4 longest-prefix-match router.
// req_ channel: one word per item. req_tuser selects add route (0) or route
// datagram (1). An add stores prefix/length/next hop/interface keyed by
// (masked prefix, length); re-adding a key overwrites it, a full table drops it.
// rsp_ channel: one word per routed datagram, none per add. rsp_tuser is the
// forward flag; a dropped datagram returns all-zero data.
// Routes live in a chain of ROUTE_ENTRIES cells, one route per cell; an item
// walks the chain one cell per cycle, so one item is in flight at a time.
// Route: the result is registered once the item leaves the last cell.
// Add: one walk when the key exists, otherwise a second walk
// to claim the lowest free cell.
// req_tready is high whenever no item is in the chain or parked; a result
// held by a stalled receiver does not block the next item. If a second result
// finishes while the first still waits, it is parked and req_tready stays low
// until the receiver takes the first.
// Reset (synchronous) empties the table and drops any item or result.
module ipv4_longest_prefix_router import lpr_pkg::*; #(
   parameter int ROUTE_ENTRIES = 64,
   parameter int PORT_BITS     = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // prefix_value[31:0] prefix_bits[37:32] has_gateway[38] gateway_addr[70:39]
   // port_index[74:71] dest_addr[106:75] hop_limit[114:107], zero pad above
   input  logic [119:0] req_tdata,
   // kind[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_port[3:0] next_hop_addr[35:4] new_hop_limit[43:36], zero pad above
   output logic [47:0]  rsp_tdata,
   // forward[0]
   output logic [0:0]   rsp_tuser
);

   logic                 act   [ROUTE_ENTRIES+1];
   lpr_word_type         word  [ROUTE_ENTRIES+1];
   logic [PORT_BITS-1:0] lane  [ROUTE_ENTRIES+1];

   logic                 head_act_ff, head_act_in;
   lpr_word_type         head_word_ff, head_word_in;
   logic [PORT_BITS-1:0] head_port_ff, head_port_in;

   lpr_state_type        state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lpr_res_type          rsp_ff, rsp_in;
   lpr_res_type          park_ff, park_in;

   logic                 accept;
   logic [LEN_BITS-1:0]  len_sat;
   logic [PORT_MAX_BITS-1:0] port_ext;
   logic [PORT_MAX_BITS-1:0] tail_port_ext;
   lpr_word_type         new_word;
   lpr_word_type         tail;
   lpr_res_type          tail_res;
   logic                 slot_free;
   logic                 tail_route;
   logic                 tail_add_done;
   logic                 tail_relaunch;

   assign accept = req_tvalid && req_tready;
   assign tail   = word[ROUTE_ENTRIES];

   always_comb begin
      len_sat  = (req_tdata[37:32] > LEN_MAX) ? LEN_MAX : req_tdata[37:32];
      port_ext = {{(PORT_MAX_BITS-OUT_PORT_BITS){1'b0}}, req_tdata[74:71]};
      new_word = '0;
      if (req_tuser[0] == KIND_ROUTE) begin
         new_word.op   = OP_ROUTE;
         new_word.addr = req_tdata[106:75];
         new_word.ttl  = req_tdata[114:107];
      end else begin
         new_word.op     = OP_UPDATE;
         new_word.addr   = req_tdata[31:0] & len_mask(len_sat);
         new_word.len    = len_sat;
         new_word.direct = !req_tdata[38];
         new_word.gway   = req_tdata[38] ? req_tdata[70:39] : '0;
      end
   end

   always_comb begin
      tail_port_ext = PORT_MAX_BITS'(lane[ROUTE_ENTRIES]);
      tail_res      = '0;
      if (tail.hit && (tail.ttl > 8'd1)) begin
         tail_res.fwd  = 1'b1;
         tail_res.port = tail_port_ext[OUT_PORT_BITS-1:0];
         tail_res.nh   = tail.direct ? tail.addr : tail.gway;
         tail_res.ttl  = tail.ttl - 8'd1;
      end
   end

   assign slot_free     = !rsp_valid_ff || rsp_tready;
   assign tail_route    = act[ROUTE_ENTRIES] && (tail.op == OP_ROUTE);
   assign tail_relaunch = act[ROUTE_ENTRIES] && (tail.op == OP_UPDATE) && !tail.hit;
   assign tail_add_done = act[ROUTE_ENTRIES] &&
                          (((tail.op == OP_UPDATE) && tail.hit) || (tail.op == OP_CLAIM));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      park_in      = park_ff;
      head_act_in  = 1'b0;
      head_word_in = new_word;
      head_port_in = port_ext[PORT_BITS-1:0];
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (accept) begin
               head_act_in = 1'b1;
               state_in    = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (tail_relaunch) begin
               head_act_in     = 1'b1;
               head_word_in    = tail;
               head_word_in.op = OP_CLAIM;
               head_port_in    = lane[ROUTE_ENTRIES];
            end else if (tail_route) begin
               if (slot_free) begin
                  rsp_in       = tail_res;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  park_in  = tail_res;
                  state_in = ST_PARK;
               end
            end else if (tail_add_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_PARK: begin
            if (slot_free) begin
               rsp_in       = park_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_act_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_act_ff  <= head_act_in;
      end
      rsp_ff       <= rsp_in;
      park_ff      <= park_in;
      head_word_ff <= head_word_in;
      head_port_ff <= head_port_in;
   end

   assign act[0]  = head_act_ff;
   assign word[0] = head_word_ff;
   assign lane[0] = head_port_ff;

   for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
      lpr_cell #(
         .PORT_BITS(PORT_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_act   (act[i]),
         .in_word  (word[i]),
         .in_port  (lane[i]),
         .out_act  (act[i+1]),
         .out_word (word[i+1]),
         .out_port (lane[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.ttl, rsp_ff.nh, rsp_ff.port};
   assign rsp_tuser  = rsp_ff.fwd;

endmodule

// ===== rtl/lpr_checker.sv =====
module lpr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [119:0] req_tdata,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 48'd0)
      else $error("dropped datagram with nonzero data");

   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[43:36] != 8'd0)
      else $error("forwarded datagram with expired ttl");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind ipv4_longest_prefix_router lpr_checker u_lpr_checker (.*);

// ===== tb/sv/ipv4_longest_prefix_router_tb.sv =====
`timescale 1ns / 100ps

module ipv4_longest_prefix_router_tb;
   import lpr_pkg::*;

   localparam int ROUTE_ENTRIES = 64;
   localparam int PORT_BITS     = 4;
   localparam int RANDOM_ITEMS  = 1330;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 2 * ROUTE_ENTRIES + 8;

   typedef struct packed {
      logic        kind;
      logic [31:0] prefix_value;
      logic [5:0]  prefix_bits;
      logic        has_gateway;
      logic [31:0] gateway_addr;
      logic [3:0]  port_index;
      logic [31:0] dest_addr;
      logic [7:0]  hop_limit;
   } route_req_type;

   class route_table_scoreboard;
      bit          slot_used   [ROUTE_ENTRIES];
      logic [31:0] slot_prefix [ROUTE_ENTRIES];
      logic [5:0]  slot_len    [ROUTE_ENTRIES];
      logic [31:0] slot_gway   [ROUTE_ENTRIES];
      bit          slot_direct [ROUTE_ENTRIES];
      logic [3:0]  slot_port   [ROUTE_ENTRIES];
      lpr_res_type pending_verdicts[$];
      int unsigned mismatch_count;
      int unsigned result_count;

      function logic [5:0] clamp_len(logic [5:0] len);
         return (len > LEN_MAX) ? LEN_MAX : len;
      endfunction

      function logic [31:0] prefix_mask(logic [5:0] len);
         if (len == 0) return '0;
         return FULL_MASK << (ADDR_BITS - len);
      endfunction

      function void learn_route(route_req_type w);
         logic [5:0]  len;
         logic [31:0] key;
         int          slot;
         len  = clamp_len(w.prefix_bits);
         key  = w.prefix_value & prefix_mask(len);
         slot = -1;
         for (int i = 0; i < ROUTE_ENTRIES && slot < 0; i++) begin
            if (slot_used[i] && slot_prefix[i] == key && slot_len[i] == len) slot = i;
         end
         for (int i = 0; i < ROUTE_ENTRIES && slot < 0; i++) begin
            if (!slot_used[i]) slot = i;
         end
         // table full and key is new
         if (slot < 0) return;
         slot_used[slot]   = 1'b1;
         slot_prefix[slot] = key;
         slot_len[slot]    = len;
         slot_direct[slot] = !w.has_gateway;
         slot_gway[slot]   = w.has_gateway ? w.gateway_addr : '0;
         slot_port[slot]   = w.port_index;
      endfunction

      function lpr_res_type route_lookup(route_req_type w);
         int          best;
         lpr_res_type r;
         best = -1;
         for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            if (slot_used[i] &&
                ((slot_prefix[i] ^ w.dest_addr) & prefix_mask(slot_len[i])) == 0)
            begin
               if (best < 0) best = i;
               else if (slot_len[i] > slot_len[best]) best = i;
            end
         end
         r = '0;
         if (best >= 0 && w.hop_limit > 1) begin
            r.fwd  = 1'b1;
            r.port = slot_port[best];
            r.nh   = slot_direct[best] ? w.dest_addr : slot_gway[best];
            r.ttl  = w.hop_limit - 8'd1;
         end
         return r;
      endfunction

      function void note_word(route_req_type w);
         if (w.kind == KIND_ADD) learn_route(w);
         else pending_verdicts.push_back(route_lookup(w));
      endfunction

      function void check_word(lpr_res_type got);
         lpr_res_type want;
         result_count++;
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result %0d unexpected: fwd=%0d port=%0d nh=%08h ttl=%0d",
                        result_count, got.fwd, got.port, got.nh, got.ttl);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("result %0d want: fwd=%0d port=%0d nh=%08h ttl=%0d",
                        result_count, want.fwd, want.port, want.nh, want.ttl);
               $display("result %0d got:  fwd=%0d port=%0d nh=%08h ttl=%0d",
                        result_count, got.fwd, got.port, got.nh, got.ttl);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   route_table_scoreboard tracker = new;
   int          send_gap_odds = 30;
   int          stall_odds    = 25;
   int unsigned cycle_count   = 0;
   logic [31:0] seen_prefix[$];
   logic [5:0]  seen_len[$];

   ipv4_longest_prefix_router #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES),
      .PORT_BITS    (PORT_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      lpr_res_type got;
      got = '{fwd: rsp_tuser[0], port: rsp_tdata[3:0], nh: rsp_tdata[35:4],
              ttl: rsp_tdata[43:36]};
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_word(got);
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < stall_odds) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // valid stays high after a word is taken unless a gap follows
   task automatic push_item(input route_req_type w);
      if ($urandom_range(0, 99) < send_gap_odds) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, w.hop_limit, w.dest_addr, w.port_index, w.gateway_addr,
                     w.has_gateway, w.prefix_bits, w.prefix_value};
      req_tuser  <= w.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_word(w);
   endtask

   task automatic send_add(input logic [31:0] pfx, input logic [5:0] bits,
                           input logic gw_en, input logic [31:0] gw, input logic [3:0] port);
      route_req_type w;
      w = '0;
      w.kind         = KIND_ADD;
      w.prefix_value = pfx;
      w.prefix_bits  = bits;
      w.has_gateway  = gw_en;
      w.gateway_addr = gw;
      w.port_index   = port;
      push_item(w);
   endtask

   task automatic send_route(input logic [31:0] dest, input logic [7:0] ttl);
      route_req_type w;
      w = '0;
      w.kind      = KIND_ROUTE;
      w.dest_addr = dest;
      w.hop_limit = ttl;
      push_item(w);
   endtask

   // adds reuse or extend known keys or pick fresh ones; lookups mostly aim at known prefixes
   function automatic route_req_type random_word();
      route_req_type w;
      int            pick;
      logic [5:0]    len;
      logic [31:0]   mask;
      w.prefix_value = $urandom;
      w.prefix_bits  = 6'($urandom);
      w.has_gateway  = 1'($urandom);
      w.gateway_addr = $urandom;
      w.port_index   = 4'($urandom);
      w.dest_addr    = $urandom;
      w.hop_limit    = 8'($urandom);
      w.kind         = ($urandom_range(0, 99) < 35) ? KIND_ADD : KIND_ROUTE;
      pick           = (seen_prefix.size() > 0) ? $urandom_range(0, seen_prefix.size() - 1) : -1;
      if (w.kind == KIND_ADD) begin
         case ($urandom_range(0, 3))
            0: if (pick >= 0) begin
               len            = tracker.clamp_len(seen_len[pick]);
               mask           = tracker.prefix_mask(len);
               w.prefix_value = (seen_prefix[pick] & mask) | ($urandom & ~mask);
               w.prefix_bits  = seen_len[pick];
            end
            1: if (pick >= 0) begin
               len            = tracker.clamp_len(seen_len[pick]);
               mask           = tracker.prefix_mask(len);
               w.prefix_value = (seen_prefix[pick] & mask) | ($urandom & ~mask);
               w.prefix_bits  = (len + $urandom_range(1, 8) > 32) ? 6'd32
                                : len + 6'($urandom_range(1, 8));
            end
            2: w.prefix_bits = 6'($urandom_range(4, 32));
            default: ;
         endcase
         seen_prefix.push_back(w.prefix_value);
         seen_len.push_back(w.prefix_bits);
      end else begin
         if (pick >= 0 && $urandom_range(0, 9) < 7) begin
            len         = tracker.clamp_len(seen_len[pick]);
            mask        = tracker.prefix_mask(len);
            w.dest_addr = (seen_prefix[pick] & mask) | ($urandom & ~mask);
            if ($urandom_range(0, 4) == 0) w.dest_addr ^= 32'h1 << $urandom_range(0, 31);
         end
         case ($urandom_range(0, 5))
            0: w.hop_limit = 8'd0;
            1: w.hop_limit = 8'd1;
            2: w.hop_limit = 8'd2;
            3: w.hop_limit = 8'd255;
            default: ;
         endcase
      end
      return w;
   endfunction

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_route(32'h0A00_0005, 8'd64);
      send_add(32'h1234_5678, 6'd0, 1'b1, 32'h0A00_0001, 4'hF);
      send_route(FULL_MASK, 8'd255);
      send_route(32'h0000_0000, 8'd1);
      send_route(32'h0102_0304, 8'd0);
      send_route(32'h0102_0304, 8'd2);
      send_add(32'hC0A8_0123, 6'd24, 1'b0, FULL_MASK, 4'd3);
      send_route(32'hC0A8_01FE, 8'd10);
      send_add(32'hC0A8_7777, 6'd16, 1'b1, 32'hC0A8_0001, 4'd5);
      send_route(32'hC0A8_0101, 8'd10);
      send_route(32'hC0A8_FF01, 8'd10);
      send_add(32'hDEAD_BEEF, 6'd63, 1'b1, FULL_MASK, 4'd0);
      send_route(32'hDEAD_BEEF, 8'd255);
      send_route(32'hDEAD_BEEE, 8'd3);
      send_add(32'hDEAD_BEEF, 6'd32, 1'b0, 32'h0, 4'd9);
      send_route(32'hDEAD_BEEF, 8'd2);
      send_add(FULL_MASK, 6'd1, 1'b1, 32'h0, 4'd1);
      send_route(32'h8000_0000, 8'd128);
      send_route(32'h7FFF_FFFF, 8'd128);
      send_add(32'h0, 6'd0, 1'b0, 32'h0, 4'd0);
      send_route(32'h1234_5678, 8'd200);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 350) stall_odds = 85;
         if (n == 700) begin
            stall_odds = 25;
            req_tvalid <= 1'b0;
            while (tracker.pending_verdicts.size() != 0) @(posedge clock);
         end
         if (n == 900) begin
            send_gap_odds = 0;
            stall_odds    = 0;
         end
         if (n == 1000) begin
            send_gap_odds = 30;
            stall_odds    = 40;
         end
         if (n == RANDOM_ITEMS - 250) begin
            send_gap_odds = 0;
            stall_odds    = 0;
         end
         push_item(random_word());
      end
      req_tvalid <= 1'b0;

      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_verdicts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
